// ===== design/mbt_pkg.sv =====
// ---------------------------------------------------------------------------
// mbt_pkg: shared definitions for the maze backtracker generator
// Grid geometry, operation and action codes, door bits, and the control
// structs that pass between the grid store, the trail stack and the top level.
// ---------------------------------------------------------------------------
package mbt_pkg;

    // Grid geometry. The coordinate fields on the ports are three bits wide,
    // so the side length is fixed here.
    localparam int GRID_SIDE = 8;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ROW_W     = 3;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int CNT_W     = 7;
    localparam int DOOR_W    = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 1'b1;

    // Operation codes carried in the input item.
    localparam logic [1:0] FUNC_STEP    = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Direction draws.
    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    // Door bits of one cell.
    localparam logic [DOOR_W-1:0] DOOR_N = 4'b0001;
    localparam logic [DOOR_W-1:0] DOOR_S = 4'b0010;
    localparam logic [DOOR_W-1:0] DOOR_E = 4'b0100;
    localparam logic [DOOR_W-1:0] DOOR_O = 4'b1000;

    typedef logic [ROW_W-1:0]  t_coord;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DOOR_W-1:0] t_doors;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_pos;

    // Result of one item.
    typedef enum logic [1:0] {
        ACT_BLOCKED   = 2'd0,
        ACT_CARVED    = 2'd1,
        ACT_BACKTRACK = 2'd2,
        ACT_IDLE      = 2'd3
    } t_action;

    // Commands to the door grid.
    typedef struct packed {
        logic   clear;
        logic   carve;
        t_pos   here;
        t_doors here_door;
        t_pos   there;
        t_doors there_door;
    } t_grid_cmd;

    // Unvisited neighbors of the current cell.
    typedef struct packed {
        logic fresh_w;
        logic fresh_e;
        logic fresh_s;
        logic fresh_n;
    } t_grid_stat;

    // Commands to the trail stack.
    typedef struct packed {
        logic restart;
        logic push;
        logic pop;
        t_pos push_pos;
        t_pos base_pos;
    } t_trail_cmd;

    // Trail stack status: empty flag and the entry below the top.
    typedef struct packed {
        logic empty;
        t_pos below;
    } t_trail_stat;

    // Saturate a coordinate to the last row or column of the grid.
    function automatic t_coord clamp_coord(input t_coord v);
        if (int'(v) >= GRID_SIDE) begin
            return t_coord'(GRID_SIDE - 1);
        end
        return v;
    endfunction

    // Linear cell index of a position.
    function automatic t_idx pos_idx(input t_pos p);
        return t_idx'(int'(p.row) * GRID_SIDE + int'(p.col));
    endfunction

endpackage

// ===== design/mbt_grid.sv =====
// ---------------------------------------------------------------------------
// mbt_grid: door store of the maze grid
// Holds four door bits per cell in registers, opens two doors per carve,
// clears the whole grid on restart, and reports which neighbors of the
// current cell are still unvisited.
// ---------------------------------------------------------------------------
module mbt_grid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbt_pkg::t_grid_cmd    i_cmd,
    input  mbt_pkg::t_pos         i_cur,
    input  mbt_pkg::t_pos         i_read_pos,
    output mbt_pkg::t_grid_stat   o_stat,
    output mbt_pkg::t_doors       o_read_doors
);

    mbt_pkg::t_doors              r_doors [mbt_pkg::CELLS];
    mbt_pkg::t_doors              n_doors [mbt_pkg::CELLS];
    logic [mbt_pkg::CELLS-1:0]    w_fresh;
    mbt_pkg::t_idx                w_here_idx;
    mbt_pkg::t_idx                w_there_idx;
    mbt_pkg::t_pos                w_pos_w;
    mbt_pkg::t_pos                w_pos_e;
    mbt_pkg::t_pos                w_pos_s;
    mbt_pkg::t_pos                w_pos_n;
    logic                         w_all_closed;

    assign w_here_idx  = mbt_pkg::pos_idx(i_cmd.here);
    assign w_there_idx = mbt_pkg::pos_idx(i_cmd.there);

    // Next value of every cell: cleared on restart, doors ORed in on a carve.
    always_comb begin
        for (int i = 0; i < mbt_pkg::CELLS; i++) begin
            n_doors[i] = r_doors[i];
            if (i_cmd.clear) begin
                n_doors[i] = '0;
            end else if (i_cmd.carve) begin
                if (mbt_pkg::t_idx'(i) == w_here_idx) begin
                    n_doors[i] = n_doors[i] | i_cmd.here_door;
                end
                if (mbt_pkg::t_idx'(i) == w_there_idx) begin
                    n_doors[i] = n_doors[i] | i_cmd.there_door;
                end
            end
        end
    end

    // Door registers; reset closes every door.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < mbt_pkg::CELLS; i++) begin
            if (!i_rst_n) begin
                r_doors[i] <= '0;
            end else begin
                r_doors[i] <= n_doors[i];
            end
        end
    end

    // A cell is unvisited while all of its doors are closed.
    always_comb begin
        for (int i = 0; i < mbt_pkg::CELLS; i++) begin
            w_fresh[i] = (r_doors[i] == '0);
        end
        w_all_closed = &w_fresh;
    end

    // Neighbor positions; each is only used when it lies inside the grid.
    always_comb begin
        w_pos_w     = i_cur;
        w_pos_w.col = i_cur.col - 1'b1;
        w_pos_e     = i_cur;
        w_pos_e.col = i_cur.col + 1'b1;
        w_pos_s     = i_cur;
        w_pos_s.row = i_cur.row + 1'b1;
        w_pos_n     = i_cur;
        w_pos_n.row = i_cur.row - 1'b1;
    end

    assign o_stat.fresh_w = (i_cur.col != '0) && w_fresh[mbt_pkg::pos_idx(w_pos_w)];
    assign o_stat.fresh_e = (i_cur.col != mbt_pkg::t_coord'(mbt_pkg::GRID_SIDE - 1))
                            && w_fresh[mbt_pkg::pos_idx(w_pos_e)];
    assign o_stat.fresh_s = (i_cur.row != mbt_pkg::t_coord'(mbt_pkg::GRID_SIDE - 1))
                            && w_fresh[mbt_pkg::pos_idx(w_pos_s)];
    assign o_stat.fresh_n = (i_cur.row != '0) && w_fresh[mbt_pkg::pos_idx(w_pos_n)];

    // Read port; a cell outside the grid reads as all doors closed.
    always_comb begin
        o_read_doors = '0;
        if ((int'(i_read_pos.row) < mbt_pkg::GRID_SIDE)
                && (int'(i_read_pos.col) < mbt_pkg::GRID_SIDE)) begin
            o_read_doors = r_doors[mbt_pkg::pos_idx(i_read_pos)];
        end
    end

`ifndef SYNTHESIS
    // A restart leaves every door closed.
    a_clear_closes_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> w_all_closed)
        else $error("grid not fully closed after restart");

    // A carve always enters a cell that has not been visited yet.
    a_carve_into_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.carve && !i_cmd.clear) |-> w_fresh[w_there_idx])
        else $error("carve into a visited cell");

    // After a carve both cells have at least one open door.
    a_carve_opens_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.carve && !i_cmd.clear) |=>
            (!w_fresh[$past(w_here_idx)] && !w_fresh[$past(w_there_idx)]))
        else $error("carve did not open doors on both sides");
`endif

endmodule

// ===== design/mbt_trail.sv =====
// ---------------------------------------------------------------------------
// mbt_trail: path stack of the maze carver
// Keeps the trail of carved cells in a memory, with the bottom entry (the
// start cell) in a register, and prefetches the entry below the top so that
// a backtrack does not wait for a memory read.
// ---------------------------------------------------------------------------
module mbt_trail (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mbt_pkg::t_trail_cmd    i_cmd,
    output mbt_pkg::t_trail_stat   o_stat
);

    mbt_pkg::t_pos   r_mem [mbt_pkg::CELLS];
    mbt_pkg::t_idx   r_top;
    mbt_pkg::t_idx   n_top;
    mbt_pkg::t_pos   r_base;
    mbt_pkg::t_pos   r_rd_data;
    mbt_pkg::t_idx   w_rd_addr;

    // Next top of stack; a push saturates at the last entry.
    always_comb begin
        n_top = r_top;
        if (i_cmd.restart) begin
            n_top = '0;
        end else if (i_cmd.push) begin
            if (r_top != mbt_pkg::t_idx'(mbt_pkg::CELLS - 1)) begin
                n_top = r_top + 1'b1;
            end
        end else if (i_cmd.pop) begin
            if (r_top != '0) begin
                n_top = r_top - 1'b1;
            end
        end
    end

    assign w_rd_addr = n_top - 1'b1;

    // Control state: top pointer and the bottom entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_base <= '0;
        end else begin
            r_top <= n_top;
            if (i_cmd.restart) begin
                r_base <= i_cmd.base_pos;
            end
        end
    end

    // Stack memory: push writes at the new top, the entry below it is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.restart) begin
            r_mem[n_top] <= i_cmd.push_pos;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // The bottom entry lives in a register.
    assign o_stat.empty = (r_top == '0);
    assign o_stat.below = (r_top == mbt_pkg::t_idx'(1)) ? r_base : r_rd_data;

endmodule

// ===== design/maze_backtracker_generator.sv =====
// ---------------------------------------------------------------------------
// maze_backtracker_generator: randomized depth-first maze carver
// Carves an 8 x 8 maze one step per item, reads the doors of a cell, or
// restarts at the configured start cell.
// ---------------------------------------------------------------------------
// m_axis_tvalid is set in the cycle after an input item is accepted.
// Throughput: one item per cycle while m_axis_tready allows; the door grid is held in
// registers and the trail stack prefetches the entry below its top, so a step never waits.
// Reset (synchronous, active low) closes all doors, sets the start cell and
// position to row 0, column 0, the visit count to one and the trail to empty.
// Configuration writes take effect at the next restart.
// ---------------------------------------------------------------------------
module maze_backtracker_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbt_pkg::ROW_W-1:0]       i_cfg_data,
    // Input items.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // dir_draw, read_row, read_col
    input  logic [1:0]                      s_axis_tuser,   // func
    // Result items.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cur_row, cur_col, action, cells_visited, done_res, cell_doors, zero pad
    output logic [23:0]                     m_axis_tdata
);

    mbt_pkg::t_coord       r_start_row;
    mbt_pkg::t_coord       r_start_col;
    mbt_pkg::t_pos         r_pos;
    mbt_pkg::t_pos         n_pos;
    mbt_pkg::t_count       r_cnt;
    mbt_pkg::t_count       n_cnt;
    mbt_pkg::t_action      w_action;
    mbt_pkg::t_doors       w_doors;
    mbt_pkg::t_pos         w_start;
    mbt_pkg::t_pos         w_read_pos;
    mbt_pkg::t_pos         w_target;
    mbt_pkg::t_doors       w_here_door;
    mbt_pkg::t_doors       w_there_door;
    logic                  w_hit;
    logic                  w_accept;
    logic [1:0]            w_func;
    logic [1:0]            w_draw;
    mbt_pkg::t_grid_cmd    w_grid_cmd;
    mbt_pkg::t_grid_stat   w_grid_stat;
    mbt_pkg::t_doors       w_read_doors;
    mbt_pkg::t_trail_cmd   w_trail_cmd;
    mbt_pkg::t_trail_stat  w_trail_stat;

    logic                  r_out_valid;
    mbt_pkg::t_pos         r_out_pos;
    mbt_pkg::t_action      r_out_action;
    mbt_pkg::t_count       r_out_cnt;
    logic                  r_out_done;
    mbt_pkg::t_doors       r_out_doors;

    // Input field unpacking.
    assign w_func         = s_axis_tuser;
    assign w_draw         = s_axis_tdata[1:0];
    assign w_read_pos.row = s_axis_tdata[4:2];
    assign w_read_pos.col = s_axis_tdata[7:5];

    // Handshake: a new item enters whenever the result register is free or drains.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Restart position from the configured start, saturated to the grid.
    assign w_start.row = mbt_pkg::clamp_coord(r_start_row);
    assign w_start.col = mbt_pkg::clamp_coord(r_start_col);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= '0;
            r_start_col <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                mbt_pkg::CFG_START_ROW: r_start_row <= i_cfg_data;
                mbt_pkg::CFG_START_COL: r_start_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Drawn direction: target cell, door bits on both sides, and whether it is still unvisited.
    always_comb begin
        w_target     = r_pos;
        w_here_door  = '0;
        w_there_door = '0;
        w_hit        = 1'b0;
        case (w_draw)
            mbt_pkg::DIR_WEST: begin
                w_target.col = r_pos.col - 1'b1;
                w_here_door  = mbt_pkg::DOOR_O;
                w_there_door = mbt_pkg::DOOR_E;
                w_hit        = w_grid_stat.fresh_w;
            end
            mbt_pkg::DIR_EAST: begin
                w_target.col = r_pos.col + 1'b1;
                w_here_door  = mbt_pkg::DOOR_E;
                w_there_door = mbt_pkg::DOOR_O;
                w_hit        = w_grid_stat.fresh_e;
            end
            mbt_pkg::DIR_SOUTH: begin
                w_target.row = r_pos.row + 1'b1;
                w_here_door  = mbt_pkg::DOOR_S;
                w_there_door = mbt_pkg::DOOR_N;
                w_hit        = w_grid_stat.fresh_s;
            end
            default: begin
                w_target.row = r_pos.row - 1'b1;
                w_here_door  = mbt_pkg::DOOR_N;
                w_there_door = mbt_pkg::DOOR_S;
                w_hit        = w_grid_stat.fresh_n;
            end
        endcase
    end

    // Operation decode and next state.
    always_comb begin
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        w_action    = mbt_pkg::ACT_IDLE;
        w_doors     = '0;
        w_grid_cmd  = '0;
        w_trail_cmd = '0;
        w_grid_cmd.here       = r_pos;
        w_grid_cmd.here_door  = w_here_door;
        w_grid_cmd.there      = w_target;
        w_grid_cmd.there_door = w_there_door;
        w_trail_cmd.push_pos  = w_target;
        w_trail_cmd.base_pos  = w_start;
        if (w_accept) begin
            unique case (w_func)
                mbt_pkg::FUNC_STEP: begin
                    if (r_cnt >= mbt_pkg::t_count'(mbt_pkg::CELLS)) begin
                        // Maze complete: nothing changes.
                        w_action = mbt_pkg::ACT_IDLE;
                    end else if (!(w_grid_stat.fresh_w || w_grid_stat.fresh_e
                            || w_grid_stat.fresh_s || w_grid_stat.fresh_n)) begin
                        // Dead end: return to the previous cell of the trail.
                        w_action = mbt_pkg::ACT_BACKTRACK;
                        if (!w_trail_stat.empty) begin
                            w_trail_cmd.pop = 1'b1;
                            n_pos           = w_trail_stat.below;
                        end
                    end else if (w_hit) begin
                        w_action         = mbt_pkg::ACT_CARVED;
                        w_grid_cmd.carve = 1'b1;
                        w_trail_cmd.push = 1'b1;
                        n_pos            = w_target;
                        n_cnt            = r_cnt + 1'b1;
                    end else begin
                        w_action = mbt_pkg::ACT_BLOCKED;
                    end
                end
                mbt_pkg::FUNC_READ: begin
                    w_doors = w_read_doors;
                end
                mbt_pkg::FUNC_RESTART: begin
                    w_grid_cmd.clear    = 1'b1;
                    w_trail_cmd.restart = 1'b1;
                    n_pos               = w_start;
                    n_cnt               = mbt_pkg::t_count'(1);
                end
                default: ;
            endcase
        end
    end

    // Position and visit count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= mbt_pkg::t_count'(1);
        end else begin
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

    // Result register: valid flag under reset, payload loaded on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_pos    <= n_pos;
            r_out_action <= w_action;
            r_out_cnt    <= n_cnt;
            r_out_done   <= (n_cnt >= mbt_pkg::t_count'(mbt_pkg::CELLS));
            r_out_doors  <= w_doors;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_doors, r_out_done, r_out_cnt,
                            r_out_action, r_out_pos.col, r_out_pos.row};

    // Door grid.
    mbt_grid u_grid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_grid_cmd),
        .i_cur        (r_pos),
        .i_read_pos   (w_read_pos),
        .o_stat       (w_grid_stat),
        .o_read_doors (w_read_doors)
    );

    // Trail stack.
    mbt_trail u_trail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_trail_cmd),
        .o_stat  (w_trail_stat)
    );

`ifndef SYNTHESIS
    // A carve counts exactly one new cell.
    a_carve_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == mbt_pkg::ACT_CARVED)) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("carve did not advance the visit count");

    // A backtrack never changes the visit count.
    a_backtrack_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == mbt_pkg::FUNC_STEP) && (w_action == mbt_pkg::ACT_BACKTRACK))
        |=> (r_cnt == $past(r_cnt)))
        else $error("backtrack changed the visit count");

    // Once the maze is complete a step leaves position and count alone.
    a_complete_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == mbt_pkg::FUNC_STEP)
            && (r_cnt >= mbt_pkg::t_count'(mbt_pkg::CELLS)))
        |=> ((r_pos == $past(r_pos)) && (r_cnt == $past(r_cnt))))
        else $error("step changed state on a complete maze");
`endif

endmodule
